[rtl/hmlf_pkg.sv]
// ----------------------------------------------------------------------------
// Hamming/Manchester LED framer package
// Shared constants, types and the Hamming(7,4) coding function.
// ----------------------------------------------------------------------------
`default_nettype none

package hmlf_pkg;

   // Frame geometry.
   localparam int PREAMBLE_LEN  = 8;
   localparam int CODED_BITS    = 7;
   localparam int DATA_BITS     = 2 * CODED_BITS;
   localparam int FRAME_BITS    = PREAMBLE_LEN + DATA_BITS;
   localparam int COUNT_WIDTH   = $clog2(FRAME_BITS + 1);

   // Preamble register value after reset.
   localparam logic [PREAMBLE_LEN-1:0] PREAMBLE_RESET = 8'hAA;

   // Coded bits queued for the serializer, most significant bit sent first.
   typedef struct packed {
      logic [FRAME_BITS-1:0]  frame;
      logic [COUNT_WIDTH-1:0] bit_count;
      logic                   close;
   } frame_load_type;

   // Hamming(7,4) code word laid out as p1 p2 d1 p3 d2 d3 d4, p1 in bit 6.
   function automatic logic [CODED_BITS-1:0] hamming_encode(input logic [3:0] nibble);
      logic d1, d2, d3, d4;
      d1 = nibble[0];
      d2 = nibble[1];
      d3 = nibble[2];
      d4 = nibble[3];
      return {d1 ^ d2 ^ d4, d1 ^ d3 ^ d4, d1, d2 ^ d3 ^ d4, d2, d3, d4};
   endfunction

endpackage

`default_nettype wire

[rtl/hmlf_channels.sv]
// ----------------------------------------------------------------------------
// Hamming/Manchester LED framer channels
// Valid/ready interfaces for the byte input, the half-bit output and the
// preamble register write port.
// ----------------------------------------------------------------------------
`default_nettype none

interface hmlf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       starts_message;
   logic       ends_message;

   modport source (output valid, data_byte, starts_message, ends_message, input ready);
   modport sink   (input valid, data_byte, starts_message, ends_message, output ready);
endinterface

interface hmlf_rsp_if;
   logic valid;
   logic ready;
   logic led_level;
   logic last_of_run;
   logic message_done;

   modport source (output valid, led_level, last_of_run, message_done, input ready);
   modport sink   (input valid, led_level, last_of_run, message_done, output ready);
endinterface

interface hmlf_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] write_data;

   modport source (output valid, write_data, input ready);
   modport sink   (input valid, write_data, output ready);
endinterface

`default_nettype wire

[rtl/hamming_manchester_led_framer.sv]
// ----------------------------------------------------------------------------
// Hamming/Manchester LED framer
// Turns message bytes into Hamming(7,4)-coded Manchester LED half-bits.
// ----------------------------------------------------------------------------
// Usage:
//   req_port carries one message byte per transfer with starts_message and
//   ends_message. rsp_port carries one LED half-bit level per transfer, with
//   last_of_run on the final result of a byte and message_done on the closing
//   LED-off result of a message. csr_port writes the 8-bit preamble pattern
//   (0xAA after reset); always ready; write it while idle, as it is not checked.
//   Each byte produces 28 half-bits, plus 16 when it starts a message and one
//   more when it ends one. The serializer emits one half-bit per cycle while
//   the receiver is ready; that shifter sets the rate.
//   A byte is taken into the input register while the previous byte is still
//   being shifted out, and it is coded and loaded in the cycle the last
//   half-bit of the previous byte goes out, so results flow without gaps.
//   From idle, a byte passes input register, shifter and result register.
//   When the receiver stalls, the result register holds and the shifter and
//   input register fill up and then drop req_port.ready.
//   Reset empties the input register, the shifter and the result register and
//   restores the preamble pattern.
// ----------------------------------------------------------------------------
`default_nettype none

module hamming_manchester_led_framer (
   input  wire         clock,
   input  wire         reset,
   hmlf_req_if.sink    req_port,
   hmlf_rsp_if.source  rsp_port,
   hmlf_csr_if.sink    csr_port
);
   import hmlf_pkg::*;

   logic [PREAMBLE_LEN-1:0]  preamble_ff, preamble_in;
   logic                     in_valid_ff, in_valid_in;
   logic [7:0]               byte_ff, byte_in;
   logic                     start_ff, start_in;
   logic                     end_ff, end_in;
   logic                     load_ready;
   logic                     req_xfer;
   logic [CODED_BITS-1:0]    code_high;
   logic [CODED_BITS-1:0]    code_low;
   frame_load_type           load;

   // Preamble register; writes are always taken.
   assign csr_port.ready = 1'b1;
   assign preamble_in    = csr_port.valid ? csr_port.write_data : preamble_ff;

   // Input register, freed when the serializer takes its contents.
   assign req_port.ready = !in_valid_ff || load_ready;
   assign req_xfer       = req_port.valid && req_port.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      byte_in     = byte_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
         byte_in     = req_port.data_byte;
         start_in    = req_port.starts_message;
         end_in      = req_port.ends_message;
      end else if (load_ready) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preamble_ff <= PREAMBLE_RESET;
         in_valid_ff <= 1'b0;
      end else begin
         preamble_ff <= preamble_in;
         in_valid_ff <= in_valid_in;
      end
      byte_ff  <= byte_in;
      start_ff <= start_in;
      end_ff   <= end_in;
   end

   // Code both nibbles and build the frame, left aligned.
   assign code_high = hamming_encode(byte_ff[7:4]);
   assign code_low  = hamming_encode(byte_ff[3:0]);

   always_comb begin
      if (start_ff) begin
         load.frame     = {preamble_ff, code_high, code_low};
         load.bit_count = COUNT_WIDTH'(FRAME_BITS);
      end else begin
         load.frame     = {code_high, code_low, {PREAMBLE_LEN{1'b0}}};
         load.bit_count = COUNT_WIDTH'(DATA_BITS);
      end
      load.close = end_ff;
   end

   hmlf_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff),
      .load       (load),
      .load_ready (load_ready),
      .rsp_port   (rsp_port)
   );

   // Checks.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_port.ready)
      else $error("preamble write port not ready");

   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !load_ready) |=> (in_valid_ff && $stable(byte_ff)))
      else $error("input register lost a pending byte");

   a_xfer_fills: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> in_valid_ff)
      else $error("accepted byte not held in input register");

endmodule

`default_nettype wire

[rtl/hmlf_serializer.sv]
// ----------------------------------------------------------------------------
// Hamming/Manchester LED framer serializer
// Shifts coded bits out as Manchester half-bits into the result register, one
// per cycle unless stalled, and closes a message with an LED-off result.
// ----------------------------------------------------------------------------
`default_nettype none

module hmlf_serializer (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   load_valid,
   input  hmlf_pkg::frame_load_type load,
   output logic                  load_ready,
   hmlf_rsp_if.source            rsp_port
);
   import hmlf_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] ONE_BIT = COUNT_WIDTH'(1);

   logic [FRAME_BITS-1:0]  frame_ff, frame_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   half_ff, half_in;
   logic                   close_ff, close_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   led_ff, led_in;
   logic                   last_ff, last_in;
   logic                   done_ff, done_in;
   logic                   busy;
   logic                   out_free;
   logic                   emit;
   logic                   final_emit;
   logic                   take;
   logic                   cur_bit;

   // Work is pending while coded bits or the close remain.
   assign busy       = (count_ff != '0) || close_ff;
   assign out_free   = !rsp_valid_ff || rsp_port.ready;
   assign emit       = busy && out_free;
   assign final_emit = emit && (((count_ff == ONE_BIT) && half_ff && !close_ff) ||
                                ((count_ff == '0) && close_ff));
   assign load_ready = !busy || final_emit;
   assign take       = load_valid && load_ready;
   assign cur_bit    = frame_ff[FRAME_BITS-1];

   // Serializer state and the next result.
   always_comb begin
      frame_in     = frame_ff;
      count_in     = count_ff;
      half_in      = half_ff;
      close_in     = close_ff;
      rsp_valid_in = rsp_valid_ff;
      led_in       = led_ff;
      last_in      = last_ff;
      done_in      = done_ff;

      if (emit) begin
         rsp_valid_in = 1'b1;
         if (count_ff != '0) begin
            // A one goes out as off then on, a zero as on then off.
            led_in  = half_ff ? cur_bit : !cur_bit;
            last_in = (count_ff == ONE_BIT) && half_ff && !close_ff;
            done_in = 1'b0;
            if (half_ff) begin
               frame_in = {frame_ff[FRAME_BITS-2:0], 1'b0};
               count_in = count_ff - ONE_BIT;
               half_in  = 1'b0;
            end else begin
               half_in = 1'b1;
            end
         end else begin
            led_in   = 1'b0;
            last_in  = 1'b1;
            done_in  = 1'b1;
            close_in = 1'b0;
         end
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (take) begin
         frame_in = load.frame;
         count_in = load.bit_count;
         half_in  = 1'b0;
         close_in = load.close;
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         half_ff      <= 1'b0;
         close_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         half_ff      <= half_in;
         close_ff     <= close_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      frame_ff <= frame_in;
      led_ff   <= led_in;
      last_ff  <= last_in;
      done_ff  <= done_in;
   end

   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.led_level    = led_ff;
   assign rsp_port.last_of_run  = last_ff;
   assign rsp_port.message_done = done_ff;

   // Checks.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(FRAME_BITS))
      else $error("serializer bit count out of range");

   a_half_needs_bit: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> (count_ff != '0))
      else $error("second half-bit pending with no coded bit");

   a_done_is_close: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> (last_ff && !led_ff))
      else $error("closing result is not a final LED-off result");

   a_load_count: assert property (@(posedge clock) disable iff (reset)
      take |=> ((count_ff == COUNT_WIDTH'(FRAME_BITS)) ||
                (count_ff == COUNT_WIDTH'(DATA_BITS))))
      else $error("serializer loaded with a bad bit count");

   a_no_load_when_busy: assert property (@(posedge clock) disable iff (reset)
      (busy && !final_emit) |-> !take)
      else $error("serializer reloaded while bits remain");

endmodule

`default_nettype wire
